@@ rtl/cte_pkg.sv @@
// Package for the credential table engine: slot count, entry and command types,
// operation codes and the reset contents of the slot table.
// No dependencies; used by cte_slot_store and credential_table_engine_unit.
`timescale 1ns / 1ps

package cte_pkg;

	// Table geometry.
	localparam int NUM_SLOTS = 16;
	localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);

	// PINs held by the two slots that are occupied after reset.
	localparam logic [63:0] PIN_ADMIN_DEFAULT = 64'h3132_3334_3536_3738;
	localparam logic [63:0] PIN_USER_DEFAULT  = 64'h3030_3030_3030_3030;

	// Result status codes.
	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FAIL = 1'b1;

	typedef enum logic [1:0] {
		OP_AUTH   = 2'd0,
		OP_ADD    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CHANGE = 2'd3
	} op_t;

	// One request.
	typedef struct packed {
		op_t         op;
		logic [63:0] pin_digits;
		logic        new_level;
		logic        target_is_admin;
		logic [3:0]  slot_index;
	} cmd_t;

	// One result.
	typedef struct packed {
		logic       status;
		logic       granted_level;
		logic [3:0] hit_slot;
	} rsp_t;

	// One table entry as stored in memory.
	typedef struct packed {
		logic        used;
		logic        admin;
		logic [63:0] pin;
	} slot_entry_t;

	// Write port of the slot store.
	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		slot_entry_t       data;
	} slot_wr_t;

	localparam rsp_t RSP_FAIL = '{status: ST_FAIL, granted_level: 1'b0, hit_slot: 4'd0};

	// Contents of an entry that has not been written since reset.
	function automatic slot_entry_t slot_reset(input logic [SLOT_W-1:0] a);
		slot_entry_t e;
		e = '0;
		if (a == SLOT_W'(0)) begin
			e.used  = 1'b1;
			e.admin = 1'b1;
			e.pin   = PIN_ADMIN_DEFAULT;
		end else if (a == SLOT_W'(1)) begin
			e.used  = 1'b1;
			e.admin = 1'b0;
			e.pin   = PIN_USER_DEFAULT;
		end
		return e;
	endfunction

endpackage

@@ rtl/cte_slot_store.sv @@
// Slot table memory with one read and one write port and a registered read.
// Entries not yet written read back as their reset contents. Depends on cte_pkg.
`timescale 1ns / 1ps

module cte_slot_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [cte_pkg::SLOT_W-1:0]  rd_addr,
	output cte_pkg::slot_entry_t        rd_data,
	input  cte_pkg::slot_wr_t           wr
);
	import cte_pkg::*;

	slot_entry_t       mem [NUM_SLOTS];
	logic              written_q [NUM_SLOTS];
	slot_entry_t       data_s1;
	logic              written_s1;
	logic [SLOT_W-1:0] addr_s1;

	// Memory array: one write and one registered read each cycle.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		data_s1 <= mem[rd_addr];
		addr_s1 <= rd_addr;
	end

	// Written flags, one per entry, cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				written_q[i] <= 1'b0;
			end
			written_s1 <= 1'b0;
		end else begin
			if (wr.en) begin
				written_q[wr.addr] <= 1'b1;
			end
			written_s1 <= written_q[rd_addr];
		end
	end

	// An entry never written shows its reset contents.
	assign rd_data = written_s1 ? data_s1 : slot_reset(addr_s1);

endmodule

@@ rtl/credential_table_engine_unit.sv @@
// Credential table engine: authenticate, add, remove and change-PIN requests.
// A request scans from slot 0 up to the slot that settles it or the last slot;
// a name-addressed request reads only the slot that it names.
// Throughput: one request at a time, paced by the single memory read port walking one
// slot per cycle. A bad slot index is answered in the cycle right after its transfer.
// The receiver cannot stall.
// Reset: asynchronous, active low; the table returns to its default two slots at once.
`timescale 1ns / 1ps

module credential_table_engine_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  cte_pkg::cmd_t cmd,
	output logic          done,
	output cte_pkg::rsp_t result
);
	import cte_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	state_t            state_q;
	cmd_t              cmd_q;
	logic [SLOT_W-1:0] addr_q;
	logic [SLOT_W-1:0] addr_s1;
	logic              issue_q;
	logic              pend_s1;
	logic              done_q;
	rsp_t              rsp_q;

	slot_entry_t       ent_s1;
	slot_wr_t          wr;
	logic              name_op;
	logic              new_name_op;
	logic              idx_ok;
	logic              hit;
	logic              finish;

	cte_slot_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (addr_q),
		.rd_data (ent_s1),
		.wr      (wr)
	);

	// Request decode.
	assign name_op     = (cmd_q.op == OP_REMOVE) || (cmd_q.op == OP_CHANGE);
	assign new_name_op = (cmd.op == OP_REMOVE) || (cmd.op == OP_CHANGE);
	assign idx_ok      = 32'(cmd.slot_index) < NUM_SLOTS;

	// Match test on the entry returned by the memory.
	always_comb begin
		case (cmd_q.op) inside
			OP_AUTH:              hit = ent_s1.used && (ent_s1.pin == cmd_q.pin_digits);
			OP_ADD:               hit = !ent_s1.used;
			OP_REMOVE, OP_CHANGE: hit = ent_s1.used && (ent_s1.admin == cmd_q.target_is_admin);
			default:              hit = 1'b0;
		endcase
	end

	assign finish = pend_s1 && (hit || name_op || (addr_s1 == SLOT_LAST));

	// Write-back of the modified entry.
	always_comb begin
		wr.en   = pend_s1 && hit && (cmd_q.op != OP_AUTH);
		wr.addr = addr_s1;
		case (cmd_q.op)
			OP_ADD: begin
				wr.data = '{used: 1'b1, admin: cmd_q.new_level, pin: cmd_q.pin_digits};
			end
			OP_CHANGE: begin
				wr.data = '{used: ent_s1.used, admin: ent_s1.admin, pin: cmd_q.pin_digits};
			end
			default: begin
				wr.data = '0;
			end
		endcase
	end

	// Request and address pipeline registers.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_q <= cmd;
		end
		addr_s1 <= addr_q;
	end

	// Sequencer state and registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			addr_q  <= '0;
			issue_q <= 1'b0;
			pend_s1 <= 1'b0;
			done_q  <= 1'b0;
			rsp_q   <= RSP_FAIL;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					pend_s1 <= 1'b0;
					if (start) begin
						if (new_name_op && !idx_ok) begin
							done_q <= 1'b1;
							rsp_q  <= RSP_FAIL;
						end else begin
							state_q <= S_SCAN;
							issue_q <= 1'b1;
							addr_q  <= new_name_op ? SLOT_W'(cmd.slot_index) : '0;
						end
					end
				end
				S_SCAN: begin
					pend_s1 <= issue_q && !finish;
					if (issue_q) begin
						if (name_op || (addr_q == SLOT_LAST)) begin
							issue_q <= 1'b0;
						end else begin
							addr_q <= addr_q + 1'b1;
						end
					end
					if (finish) begin
						state_q <= S_IDLE;
						issue_q <= 1'b0;
						done_q  <= 1'b1;
						if (hit) begin
							rsp_q.status        <= ST_OK;
							rsp_q.granted_level <= (cmd_q.op == OP_AUTH) ? ent_s1.admin : 1'b0;
							rsp_q.hit_slot      <= 4'(addr_s1);
						end else begin
							rsp_q <= RSP_FAIL;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = rsp_q;

	// The result strobe comes only when the sequencer has returned to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a request is still in progress");

	// The table is written only while a request is being worked on.
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> busy)
		else $error("slot table written outside a request");

	// Every result follows a request taken or worked on in the previous cycle.
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result strobe without a request");

	// A failed request carries zero level and slot.
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == ST_FAIL)) |->
			((result.granted_level == 1'b0) && (result.hit_slot == 4'd0)))
		else $error("failure result carries a level or slot");

endmodule
